### design/vtn_pkg.sv
// Shared types, constants and helpers for the vertex transform pipeline.
package vtn_pkg;

  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 63;
  localparam int ENT_W     = 21;

  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_COL0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_COL1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_COL2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_COL3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_COL0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_COL1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_COL2 = 3'd6;

  localparam logic [CFG_W-1:0] ONE_Q16 = 63'd65536;

  localparam int VEC_W      = 38;
  localparam int MAG_W      = 37;
  localparam int BL_W       = 6;
  localparam int NRM_W      = 30;
  localparam int SQ_W       = 60;
  localparam int SUM_W      = 62;
  localparam int ROOT_W     = 31;
  localparam int NUM_W      = 46;
  localparam int Q_W        = 15;
  localparam int UNIT_W     = 16;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 15;
  localparam int FRONT_LAT  = 5;
  localparam int UNIT_LAT   = FRONT_LAT + SQRT_STEPS + DIV_STEPS + 1;
  localparam int MV_LAT     = 2;
  localparam int POS_LAT    = 2;
  localparam int PIPE_LAT   = MV_LAT + UNIT_LAT;

  typedef logic [CFG_W-1:0]        col_t;
  typedef logic signed [VEC_W-1:0] vcomp_t;
  typedef logic signed [15:0]      s16_t;
  typedef logic signed [31:0]      s32_t;

  function automatic logic signed [ENT_W-1:0] entry_of(input col_t col, input int row);
    entry_of = col[row*ENT_W +: ENT_W];
  endfunction

endpackage

### design/vtn_if.sv
// Stream and configuration interfaces of the vertex transform block.
interface vtn_vtx_in_if;
  import vtn_pkg::*;
  logic valid;
  logic ready;
  s32_t pos_x, pos_y, pos_z;
  logic [31:0] tex_u, tex_v;
  s16_t nrm_x, nrm_y, nrm_z;
  s16_t tan_x, tan_y, tan_z;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                  nrm_x, nrm_y, nrm_z, tan_x, tan_y, tan_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                nrm_x, nrm_y, nrm_z, tan_x, tan_y, tan_z, output ready);
endinterface

interface vtn_vtx_out_if;
  import vtn_pkg::*;
  logic valid;
  logic ready;
  s32_t world_x, world_y, world_z;
  logic [31:0] out_u, out_v;
  s16_t unit_nrm_x, unit_nrm_y, unit_nrm_z;
  s16_t unit_tan_x, unit_tan_y, unit_tan_z;
  modport source (output valid, world_x, world_y, world_z, out_u, out_v,
                  unit_nrm_x, unit_nrm_y, unit_nrm_z,
                  unit_tan_x, unit_tan_y, unit_tan_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, out_u, out_v,
                unit_nrm_x, unit_nrm_y, unit_nrm_z,
                unit_tan_x, unit_tan_y, unit_tan_z, output ready);
endinterface

interface vtn_cfg_if;
  import vtn_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  col_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/vertex_transform_normalize_top.sv
// Vertex transform top: configuration registers, pipeline control, datapaths.
// One vertex word enters per clock while the output is not stalled; its latency is set
// by the 31-step square root and 15-step divider stages of the normalize path. A
// stalled output holds the whole pipeline.
module vertex_transform_normalize_top
  import vtn_pkg::*;
(
  input logic clk,
  input logic rst,
  vtn_vtx_in_if.sink    vtx_in,
  vtn_vtx_out_if.source vtx_out,
  vtn_cfg_if.sink       cfg
);

  col_t cfg_reg [NUM_REGS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg[REG_AFFINE_COL0] <= ONE_Q16;
      cfg_reg[REG_AFFINE_COL1] <= ONE_Q16 << ENT_W;
      cfg_reg[REG_AFFINE_COL2] <= ONE_Q16 << (2 * ENT_W);
      cfg_reg[REG_AFFINE_COL3] <= '0;
      cfg_reg[REG_NORMAL_COL0] <= ONE_Q16;
      cfg_reg[REG_NORMAL_COL1] <= ONE_Q16 << ENT_W;
      cfg_reg[REG_NORMAL_COL2] <= ONE_Q16 << (2 * ENT_W);
    end else if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_REGS)) begin
      cfg_reg[cfg.index] <= cfg.data;
    end
  end

  logic [PIPE_LAT-1:0] vld;
  logic en;

  assign en           = !vld[PIPE_LAT-1] || vtx_out.ready;
  assign vtx_in.ready = en;
  assign vtx_out.valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], vtx_in.valid};
    end
  end

  s32_t wx, wy, wz;
  vtn_pos u_pos (
    .clk(clk), .en(en),
    .col0(cfg_reg[REG_AFFINE_COL0]), .col1(cfg_reg[REG_AFFINE_COL1]),
    .col2(cfg_reg[REG_AFFINE_COL2]), .col3(cfg_reg[REG_AFFINE_COL3]),
    .px(vtx_in.pos_x), .py(vtx_in.pos_y), .pz(vtx_in.pos_z),
    .wx(wx), .wy(wy), .wz(wz)
  );

  vcomp_t nv [3];
  vcomp_t tv [3];
  s16_t   nu [3];
  s16_t   tu [3];

  vtn_matvec u_nrm_mv (
    .clk(clk), .en(en),
    .col0(cfg_reg[REG_NORMAL_COL0]), .col1(cfg_reg[REG_NORMAL_COL1]),
    .col2(cfg_reg[REG_NORMAL_COL2]),
    .x0(vtx_in.nrm_x), .x1(vtx_in.nrm_y), .x2(vtx_in.nrm_z), .v(nv)
  );

  vtn_matvec u_tan_mv (
    .clk(clk), .en(en),
    .col0(cfg_reg[REG_AFFINE_COL0]), .col1(cfg_reg[REG_AFFINE_COL1]),
    .col2(cfg_reg[REG_AFFINE_COL2]),
    .x0(vtx_in.tan_x), .x1(vtx_in.tan_y), .x2(vtx_in.tan_z), .v(tv)
  );

  vtn_unitize u_nrm_unit (.clk(clk), .en(en), .v(nv), .u(nu));
  vtn_unitize u_tan_unit (.clk(clk), .en(en), .v(tv), .u(tu));

  localparam int POS_DLY = PIPE_LAT - POS_LAT;

  s32_t        pos_d [POS_DLY][3];
  logic [31:0] tex_d [PIPE_LAT][2];

  always_ff @(posedge clk) begin
    if (en) begin
      pos_d[0][0] <= wx;
      pos_d[0][1] <= wy;
      pos_d[0][2] <= wz;
      for (int i = 1; i < POS_DLY; i++) pos_d[i] <= pos_d[i-1];
      tex_d[0][0] <= vtx_in.tex_u;
      tex_d[0][1] <= vtx_in.tex_v;
      for (int i = 1; i < PIPE_LAT; i++) tex_d[i] <= tex_d[i-1];
    end
  end

  assign vtx_out.world_x    = pos_d[POS_DLY-1][0];
  assign vtx_out.world_y    = pos_d[POS_DLY-1][1];
  assign vtx_out.world_z    = pos_d[POS_DLY-1][2];
  assign vtx_out.out_u      = tex_d[PIPE_LAT-1][0];
  assign vtx_out.out_v      = tex_d[PIPE_LAT-1][1];
  assign vtx_out.unit_nrm_x = nu[0];
  assign vtx_out.unit_nrm_y = nu[1];
  assign vtx_out.unit_nrm_z = nu[2];
  assign vtx_out.unit_tan_x = tu[0];
  assign vtx_out.unit_tan_y = tu[1];
  assign vtx_out.unit_tan_z = tu[2];

endmodule

### design/vtn_pos.sv
// Affine position transform: products, then sum, round and saturate.
module vtn_pos
  import vtn_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  col_t col0,
  input  col_t col1,
  input  col_t col2,
  input  col_t col3,
  input  s32_t px,
  input  s32_t py,
  input  s32_t pz,
  output s32_t wx,
  output s32_t wy,
  output s32_t wz
);

  logic signed [52:0] prod [3][3];
  logic signed [ENT_W-1:0] tr [3];
  s32_t res [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= entry_of(col0, r) * px;
        prod[r][1] <= entry_of(col1, r) * py;
        prod[r][2] <= entry_of(col2, r) * pz;
        tr[r]      <= entry_of(col3, r);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [55:0] acc;
    logic signed [39:0] y;
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        acc = 56'(prod[r][0]) + 56'(prod[r][1]) + 56'(prod[r][2])
            + (56'(tr[r]) <<< 16) + 56'sd32768;
        y = acc[55:16];
        if (y > 40'sd2147483647) res[r] <= 32'sh7fffffff;
        else if (y < -40'sd2147483648) res[r] <= 32'sh80000000;
        else res[r] <= y[31:0];
      end
    end
  end

  assign wx = res[0];
  assign wy = res[1];
  assign wz = res[2];

endmodule

### design/vtn_matvec.sv
// 3x3 matrix times a Q1.14 vector: products, then row sums.
module vtn_matvec
  import vtn_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  col_t   col0,
  input  col_t   col1,
  input  col_t   col2,
  input  s16_t   x0,
  input  s16_t   x1,
  input  s16_t   x2,
  output vcomp_t v [3]
);

  logic signed [36:0] prod [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= entry_of(col0, r) * x0;
        prod[r][1] <= entry_of(col1, r) * x1;
        prod[r][2] <= entry_of(col2, r) * x2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        v[r] <= VEC_W'(prod[r][0]) + VEC_W'(prod[r][1]) + VEC_W'(prod[r][2]);
      end
    end
  end

endmodule

### design/vtn_unitize.sv
// Scale a vector to unit length: normalize, square sum, root, divide.
module vtn_unitize
  import vtn_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  vcomp_t v [3],
  output s16_t   u [3]
);

  function automatic logic [BL_W-1:0] bitlen(input logic [MAG_W-1:0] x);
    logic [BL_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (x[i]) n = BL_W'(i + 1);
    end
    return n;
  endfunction

  logic [MAG_W-1:0] mag1 [3], mag2 [3], mx1;
  logic [2:0]       neg1, neg2, neg3, neg4, neg5;
  logic             zero2, zero3, zero4, zero5;
  logic [BL_W-1:0]  bl2;
  logic [NRM_W-1:0] nm3 [3], nm4 [3], nm5 [3];
  logic [SQ_W-1:0]  sq4 [3];

  logic [MAG_W-1:0] mag_c [3];
  logic [MAG_W-1:0] mx_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = v[i][VEC_W-1] ? MAG_W'(-v[i]) : MAG_W'(v[i]);
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    logic [MAG_W-1:0] sh;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= mag_c[i];
        neg1[i] <= v[i][VEC_W-1];
      end
      mx1 <= mx_c;

      mag2  <= mag1;
      neg2  <= neg1;
      bl2   <= bitlen(mx1);
      zero2 <= (mx1 == '0);

      for (int i = 0; i < 3; i++) begin
        if (bl2 > BL_W'(NRM_W)) sh = mag2[i] >> (bl2 - BL_W'(NRM_W));
        else sh = mag2[i] << (BL_W'(NRM_W) - bl2);
        nm3[i] <= sh[NRM_W-1:0];
      end
      neg3  <= neg2;
      zero3 <= zero2;

      for (int i = 0; i < 3; i++) begin
        sq4[i] <= SQ_W'(nm3[i]) * SQ_W'(nm3[i]);
      end
      nm4   <= nm3;
      neg4  <= neg3;
      zero4 <= zero3;

      nm5   <= nm4;
      neg5  <= neg4;
      zero5 <= zero4;
    end
  end

  logic [SUM_W-1:0]  sq_rem  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] sq_root [SQRT_STEPS+1];
  logic [NRM_W-1:0]  sq_nm   [SQRT_STEPS+1][3];
  logic [2:0]        sq_neg  [SQRT_STEPS+1];
  logic              sq_zero [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0] <= SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
    end
  end
  assign sq_root[0] = '0;
  assign sq_nm[0]   = nm5;
  assign sq_neg[0]  = neg5;
  assign sq_zero[0] = zero5;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int B = SQRT_STEPS - 1 - k;
    logic [SUM_W:0] trial;
    assign trial = ((SUM_W+1)'(sq_root[k]) << (B + 1)) | ((SUM_W+1)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, sq_rem[k]} >= trial) begin
          sq_rem[k+1]  <= sq_rem[k] - trial[SUM_W-1:0];
          sq_root[k+1] <= sq_root[k] | (ROOT_W'(1) << B);
        end else begin
          sq_rem[k+1]  <= sq_rem[k];
          sq_root[k+1] <= sq_root[k];
        end
        sq_nm[k+1]   <= sq_nm[k];
        sq_neg[k+1]  <= sq_neg[k];
        sq_zero[k+1] <= sq_zero[k];
      end
    end
  end

  logic [NUM_W-1:0]  dv_rem  [DIV_STEPS+1][3];
  logic [Q_W-1:0]    dv_q    [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dv_len  [DIV_STEPS+1];
  logic [2:0]        dv_neg  [DIV_STEPS+1];
  logic              dv_zero [DIV_STEPS+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = (NUM_W'(sq_nm[SQRT_STEPS][i]) << 14)
                   + NUM_W'(sq_root[SQRT_STEPS] >> 1);
      dv_q[0][i]   = '0;
    end
  end
  assign dv_len[0]  = sq_root[SQRT_STEPS];
  assign dv_neg[0]  = sq_neg[SQRT_STEPS];
  assign dv_zero[0] = sq_zero[SQRT_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    logic [NUM_W-1:0] dsh;
    assign dsh = NUM_W'(dv_len[k]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[k][i] >= dsh) begin
            dv_rem[k+1][i] <= dv_rem[k][i] - dsh;
            dv_q[k+1][i]   <= dv_q[k][i] | (Q_W'(1) << B);
          end else begin
            dv_rem[k+1][i] <= dv_rem[k][i];
            dv_q[k+1][i]   <= dv_q[k][i];
          end
        end
        dv_len[k+1]  <= dv_len[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_zero[k+1] <= dv_zero[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [UNIT_W-1:0] q;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q = UNIT_W'(dv_q[DIV_STEPS][i]);
        if (dv_zero[DIV_STEPS]) u[i] <= '0;
        else if (dv_neg[DIV_STEPS][i]) u[i] <= -q;
        else u[i] <= q;
      end
    end
  end

endmodule

### tb/tb_vertex_transform_normalize_top.sv
// Self-checking testbench for the vertex transform: prediction, stimulus and checks.
module tb_vertex_transform_normalize_top;
  import vtn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = PIPE_LAT + 20;

  typedef struct {
    s32_t pos_x, pos_y, pos_z;
    logic [31:0] tex_u, tex_v;
    s16_t nrm_x, nrm_y, nrm_z;
    s16_t tan_x, tan_y, tan_z;
  } vertex_t;

  typedef struct {
    s32_t world_x, world_y, world_z;
    logic [31:0] out_u, out_v;
    s16_t unit_nrm_x, unit_nrm_y, unit_nrm_z;
    s16_t unit_tan_x, unit_tan_y, unit_tan_z;
  } world_vertex_t;

  logic clk;
  logic rst;
  vtn_vtx_in_if  vtx_in_bus ();
  vtn_vtx_out_if vtx_out_bus ();
  vtn_cfg_if     cfg_bus ();

  vertex_transform_normalize_top dut (
    .clk     (clk),
    .rst     (rst),
    .vtx_in  (vtx_in_bus),
    .vtx_out (vtx_out_bus),
    .cfg     (cfg_bus)
  );

  col_t          matrix_cols [NUM_REGS];
  world_vertex_t pending_vertices [$];
  int            error_count;
  int            vertices_sent;
  int            vertices_checked;
  int            cycle_count;
  int            burst_left;
  int            gap_max;
  int            stall_pct;
  int            hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint entry_at(input col_t col, input int row);
    logic signed [ENT_W-1:0] e;
    e = col[row*ENT_W +: ENT_W];
    return longint'(e);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void unit_vector(input longint v0, input longint v1, input longint v2,
                                      output s16_t o0, output s16_t o1, output s16_t o2);
    longint          comp [3];
    longint unsigned mag [3];
    longint unsigned top_mag, sum_sq, len, q;
    s16_t            res [3];
    int              nbits;
    comp[0] = v0;
    comp[1] = v1;
    comp[2] = v2;
    top_mag = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i] < 0 ? longint'(-comp[i]) : comp[i];
      if (mag[i] > top_mag) top_mag = mag[i];
    end
    if (top_mag == 0) begin
      o0 = '0;
      o1 = '0;
      o2 = '0;
      return;
    end
    nbits = 0;
    while (top_mag != 0) begin
      nbits++;
      top_mag >>= 1;
    end
    sum_sq = 0;
    for (int i = 0; i < 3; i++) begin
      if (nbits > 30) mag[i] >>= (nbits - 30);
      else mag[i] <<= (30 - nbits);
      sum_sq += mag[i] * mag[i];
    end
    len = root_floor(sum_sq);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 64'd16384 + (len >> 1)) / len;
      res[i] = comp[i] < 0 ? s16_t'(-q) : s16_t'(q);
    end
    o0 = res[0];
    o1 = res[1];
    o2 = res[2];
  endfunction

  function automatic world_vertex_t transform_vertex(input vertex_t vx);
    world_vertex_t w;
    longint p [3], n [3], t [3], acc [3], nv [3], tv [3];
    s32_t   wp [3];
    longint y;
    p = '{longint'(vx.pos_x), longint'(vx.pos_y), longint'(vx.pos_z)};
    n = '{longint'(vx.nrm_x), longint'(vx.nrm_y), longint'(vx.nrm_z)};
    t = '{longint'(vx.tan_x), longint'(vx.tan_y), longint'(vx.tan_z)};
    for (int r = 0; r < 3; r++) begin
      acc[r] = entry_at(matrix_cols[REG_AFFINE_COL3], r) * 65536;
      nv[r] = 0;
      tv[r] = 0;
      for (int j = 0; j < 3; j++) begin
        acc[r] += entry_at(matrix_cols[REG_AFFINE_COL0 + j], r) * p[j];
        tv[r]  += entry_at(matrix_cols[REG_AFFINE_COL0 + j], r) * t[j];
        nv[r]  += entry_at(matrix_cols[REG_NORMAL_COL0 + j], r) * n[j];
      end
      y = (acc[r] + 32768) >>> 16;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      wp[r] = s32_t'(y);
    end
    w.world_x = wp[0];
    w.world_y = wp[1];
    w.world_z = wp[2];
    w.out_u = vx.tex_u;
    w.out_v = vx.tex_v;
    unit_vector(nv[0], nv[1], nv[2], w.unit_nrm_x, w.unit_nrm_y, w.unit_nrm_z);
    unit_vector(tv[0], tv[1], tv[2], w.unit_tan_x, w.unit_tan_y, w.unit_tan_z);
    return w;
  endfunction

  function automatic vertex_t make_vertex(input int p, input logic [31:0] tex,
                                          input int n, input int t);
    vertex_t vx;
    vx.pos_x = p;  vx.pos_y = p;  vx.pos_z = p;
    vx.tex_u = tex; vx.tex_v = ~tex;
    vx.nrm_x = s16_t'(n);  vx.nrm_y = s16_t'(n);  vx.nrm_z = s16_t'(n);
    vx.tan_x = s16_t'(t);  vx.tan_y = s16_t'(-t); vx.tan_z = s16_t'(t);
    return vx;
  endfunction

  function automatic s16_t rand_unit_comp();
    case ($urandom_range(0, 3))
      0: return s16_t'($urandom);
      1: return s16_t'($urandom_range(0, 32767)) - 16'sd16384;
      2: return s16_t'($urandom_range(0, 15)) - 16'sd8;
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t vx;
    vx.pos_x = $urandom_range(0, 3) == 0 ? s32_t'($urandom_range(0, 1 << 20)) : $urandom;
    vx.pos_y = $urandom;
    vx.pos_z = $urandom;
    vx.tex_u = $urandom;
    vx.tex_v = $urandom;
    vx.nrm_x = rand_unit_comp();
    vx.nrm_y = rand_unit_comp();
    vx.nrm_z = rand_unit_comp();
    vx.tan_x = rand_unit_comp();
    vx.tan_y = rand_unit_comp();
    vx.tan_z = rand_unit_comp();
    if ($urandom_range(0, 19) == 0) begin
      vx.nrm_x = '0; vx.nrm_y = '0; vx.nrm_z = '0;
    end
    if ($urandom_range(0, 19) == 0) begin
      vx.tan_x = '0; vx.tan_y = '0; vx.tan_z = '0;
    end
    return vx;
  endfunction

  function automatic logic [ENT_W-1:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return 21'($urandom);
      1: return 21'(($urandom_range(0, 131072)) - 65536);
      2: return 21'(($urandom_range(0, 64)) - 32);
      3: return $urandom_range(0, 1) ? 21'h0fffff : 21'h100000;
      default: return $urandom_range(0, 1) ? 21'h010000 : 21'h000000;
    endcase
  endfunction

  function automatic col_t rand_col();
    return {rand_entry(), rand_entry(), rand_entry()};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input col_t data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (index < NUM_REGS) matrix_cols[index] = data;
    @(posedge clk);
  endtask

  task automatic send_vertex(input vertex_t vx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        vtx_in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    vtx_in_bus.valid <= 1'b1;
    vtx_in_bus.pos_x <= vx.pos_x;
    vtx_in_bus.pos_y <= vx.pos_y;
    vtx_in_bus.pos_z <= vx.pos_z;
    vtx_in_bus.tex_u <= vx.tex_u;
    vtx_in_bus.tex_v <= vx.tex_v;
    vtx_in_bus.nrm_x <= vx.nrm_x;
    vtx_in_bus.nrm_y <= vx.nrm_y;
    vtx_in_bus.nrm_z <= vx.nrm_z;
    vtx_in_bus.tan_x <= vx.tan_x;
    vtx_in_bus.tan_y <= vx.tan_y;
    vtx_in_bus.tan_z <= vx.tan_z;
    do @(posedge clk); while (!vtx_in_bus.ready);
    pending_vertices.insert(pending_vertices.size(), transform_vertex(vx));
    vertices_sent++;
  endtask

  task automatic drain();
    vtx_in_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      vtx_out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      vtx_out_bus.ready <= 1'b0;
      hold_left--;
    end else if (cycle_count % 97 < 12) begin
      vtx_out_bus.ready <= 1'b1;
    end else begin
      vtx_out_bus.ready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    world_vertex_t exp_v;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && vtx_out_bus.valid && vtx_out_bus.ready) begin
      if (pending_vertices.size() == 0) begin
        $error("output word with no expected vertex");
        error_count++;
      end else begin
        exp_v = pending_vertices.pop_front();
        vertices_checked++;
        if (vtx_out_bus.world_x !== exp_v.world_x) begin
          $error("world_x expected %0d got %0d", exp_v.world_x, vtx_out_bus.world_x);
          error_count++;
        end
        if (vtx_out_bus.world_y !== exp_v.world_y) begin
          $error("world_y expected %0d got %0d", exp_v.world_y, vtx_out_bus.world_y);
          error_count++;
        end
        if (vtx_out_bus.world_z !== exp_v.world_z) begin
          $error("world_z expected %0d got %0d", exp_v.world_z, vtx_out_bus.world_z);
          error_count++;
        end
        if (vtx_out_bus.out_u !== exp_v.out_u) begin
          $error("out_u expected %h got %h", exp_v.out_u, vtx_out_bus.out_u);
          error_count++;
        end
        if (vtx_out_bus.out_v !== exp_v.out_v) begin
          $error("out_v expected %h got %h", exp_v.out_v, vtx_out_bus.out_v);
          error_count++;
        end
        if (vtx_out_bus.unit_nrm_x !== exp_v.unit_nrm_x) begin
          $error("unit_nrm_x expected %0d got %0d", exp_v.unit_nrm_x, vtx_out_bus.unit_nrm_x);
          error_count++;
        end
        if (vtx_out_bus.unit_nrm_y !== exp_v.unit_nrm_y) begin
          $error("unit_nrm_y expected %0d got %0d", exp_v.unit_nrm_y, vtx_out_bus.unit_nrm_y);
          error_count++;
        end
        if (vtx_out_bus.unit_nrm_z !== exp_v.unit_nrm_z) begin
          $error("unit_nrm_z expected %0d got %0d", exp_v.unit_nrm_z, vtx_out_bus.unit_nrm_z);
          error_count++;
        end
        if (vtx_out_bus.unit_tan_x !== exp_v.unit_tan_x) begin
          $error("unit_tan_x expected %0d got %0d", exp_v.unit_tan_x, vtx_out_bus.unit_tan_x);
          error_count++;
        end
        if (vtx_out_bus.unit_tan_y !== exp_v.unit_tan_y) begin
          $error("unit_tan_y expected %0d got %0d", exp_v.unit_tan_y, vtx_out_bus.unit_tan_y);
          error_count++;
        end
        if (vtx_out_bus.unit_tan_z !== exp_v.unit_tan_z) begin
          $error("unit_tan_z expected %0d got %0d", exp_v.unit_tan_z, vtx_out_bus.unit_tan_z);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_matrices();
    send_vertex(make_vertex(0, 32'h0000_0000, 0, 0));
    send_vertex(make_vertex(32'sh7fff_ffff, 32'hffff_ffff, 16'sh7fff, 16'sh7fff));
    send_vertex(make_vertex(32'sh8000_0000, 32'h5a5a_a5a5, 16'sh8000, 16'sh8000));
    send_vertex(make_vertex(1, 32'h0000_0001, 1, -1));
    send_vertex(make_vertex(-1, 32'h8000_0000, -1, 16384));
    send_vertex(make_vertex(32'sh0001_8000, 32'h1234_5678, 16384, 0));
    drain();
  endtask

  task automatic test_extreme_matrices();
    col_t all_max, all_min;
    all_max = {3{21'h0fffff}};
    all_min = {3{21'h100000}};
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < NUM_REGS; r++)
        write_reg(CFG_IDX_W'(r), k == 0 ? all_max : (k == 1 ? all_min : '0));
      send_vertex(make_vertex(32'sh7fff_ffff, 32'hffff_ffff, 16'sh7fff, 16'sh8000));
      send_vertex(make_vertex(32'sh8000_0000, 32'h0, 16'sh8000, 16'sh7fff));
      send_vertex(make_vertex(32'sh0000_8000, 32'hdead_beef, 1, 1));
      send_vertex(make_vertex(-32'sh0000_8000, 32'hcafe_f00d, 0, -2));
      drain();
    end
  endtask

  task automatic test_unused_index();
    write_reg(REG_AFFINE_COL0, 63'd65536);
    write_reg(REG_AFFINE_COL1, 63'd65536 << ENT_W);
    write_reg(REG_AFFINE_COL2, 63'd65536 << (2 * ENT_W));
    write_reg(REG_AFFINE_COL3, {21'h000100, 21'h1fff00, 21'h008000});
    write_reg(REG_UNUSED, {3{21'h0fffff}});
    send_vertex(make_vertex(32'sh0002_0000, 32'h0f0f_0f0f, 100, -200));
    send_vertex(make_vertex(-32'sh0003_0000, 32'hf0f0_f0f0, 0, 16'sh7fff));
    drain();
  endtask

  task automatic test_random_stream(input int vertex_total);
    int chunk;
    while (vertex_total > 0) begin
      for (int r = 0; r < NUM_REGS; r++)
        if ($urandom_range(0, 3) != 0) write_reg(CFG_IDX_W'(r), rand_col());
      gap_max = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
      stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 70);
      chunk = $urandom_range(40, 120);
      for (int i = 0; i < chunk && vertex_total > 0; i++, vertex_total--)
        send_vertex(rand_vertex());
      drain();
    end
  endtask

  task automatic test_backpressure();
    gap_max = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_left = 300;
    for (int i = 0; i < 120; i++) send_vertex(rand_vertex());
    drain();
  endtask

  initial begin
    error_count = 0;
    vertices_sent = 0;
    vertices_checked = 0;
    cycle_count = 0;
    burst_left = 0;
    gap_max = 4;
    stall_pct = 20;
    hold_left = 0;
    matrix_cols[REG_AFFINE_COL0] = 63'd65536;
    matrix_cols[REG_AFFINE_COL1] = 63'd65536 << ENT_W;
    matrix_cols[REG_AFFINE_COL2] = 63'd65536 << (2 * ENT_W);
    matrix_cols[REG_AFFINE_COL3] = '0;
    matrix_cols[REG_NORMAL_COL0] = 63'd65536;
    matrix_cols[REG_NORMAL_COL1] = 63'd65536 << ENT_W;
    matrix_cols[REG_NORMAL_COL2] = 63'd65536 << (2 * ENT_W);
    rst = 1'b1;
    vtx_in_bus.valid = 1'b0;
    vtx_in_bus.pos_x = '0; vtx_in_bus.pos_y = '0; vtx_in_bus.pos_z = '0;
    vtx_in_bus.tex_u = '0; vtx_in_bus.tex_v = '0;
    vtx_in_bus.nrm_x = '0; vtx_in_bus.nrm_y = '0; vtx_in_bus.nrm_z = '0;
    vtx_in_bus.tan_x = '0; vtx_in_bus.tan_y = '0; vtx_in_bus.tan_z = '0;
    vtx_out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_matrices();
    test_extreme_matrices();
    test_unused_index();
    test_backpressure();
    test_random_stream(560);
    drain();

    $display("vertices sent %0d, checked %0d, across reset, extreme and random matrices",
             vertices_sent, vertices_checked);
    $display("with sender gaps, receiver stalls and a long output hold-off");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
